### rtl/u8dec_pkg.sv
// Package for the UTF-8 stream decoder: shared constants, sequence length
// codes and the job descriptor passed from the front end to the back end.
// No dependencies.
package u8dec_pkg;

  // Code point width and special values.
  localparam int unsigned CpWidth = 21;
  localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'd63;
  localparam logic [CpWidth-1:0] END_MARKER_CP = 21'd0;
  localparam logic [CpWidth-1:0] MIN_CP_LEN2 = 21'h00080;
  localparam logic [CpWidth-1:0] MIN_CP_LEN3 = 21'h00800;
  localparam logic [CpWidth-1:0] MIN_CP_LEN4 = 21'h10000;
  localparam logic [CpWidth-1:0] MAX_CP = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SURROGATE_LO = 21'h0D800;
  localparam logic [CpWidth-1:0] SURROGATE_HI = 21'h0DFFF;

  // Sequence lengths, also used as byte counts on results.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  // Depth of the job queue between front end and back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // One job: a run of replacement results followed by an optional tail result.
  typedef struct packed {
    logic [2:0]         rep_count;
    logic               tail_valid;
    logic [CpWidth-1:0] tail_cp;
    logic [2:0]         tail_used;
    logic               tail_bad;
    logic               tail_done;
  } job_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### rtl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: front end, job queue and back end.
// Depends on u8dec_pkg, u8dec_front, u8dec_queue and u8dec_back.

// The decoder takes one text byte per cycle while the job queue is not full
// and gives zero to four results for it, in order, with run_last marking the
// final result of each byte. A byte that only opens or extends a sequence
// gives no result. A byte that gives n results loads the output register n
// times, one result per cycle while out_stall is low. Between the byte
// classifier and the result expander sits a two-entry job queue; the input
// stalls only when that queue is full. Results pass through a job queue
// entry and then the output register before they appear on the output. A
// zero byte flushes an open sequence as '?' results and then gives an end
// marker; decoding continues afterwards from idle.
module utf8_stream_decoder_core
  import u8dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CpWidth-1:0] code_point,
  output logic [2:0]         bytes_used,
  output logic               bad_sequence,
  output logic               text_done,
  output logic               run_last
);

  job_t          push_job;
  job_t          head_job;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  // Byte classification and sequence tracking.
  u8dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job)
  );

  // Job queue.
  u8dec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Result expansion and output register.
  u8dec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .bytes_used   (bytes_used),
    .bad_sequence (bad_sequence),
    .text_done    (text_done),
    .run_last     (run_last)
  );

endmodule

### rtl/u8dec_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and turns each byte into a job descriptor. Depends on u8dec_pkg.
module u8dec_front
  import u8dec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    text_byte,
  input  queue_status_t q_status,
  output logic          push,
  output job_t          job
);

  logic [2:0]         expected_length;
  logic [1:0]         gathered_count;
  logic [CpWidth-1:0] partial_value;

  logic [2:0]         expected_length_next;
  logic [1:0]         gathered_count_next;
  logic [CpWidth-1:0] partial_value_next;

  logic               accept;
  logic               seq_open;
  logic               is_cont;
  logic [CpWidth-1:0] cp_gathered;
  logic [2:0]         count_gathered;
  logic               overlong;
  logic               out_of_range;

  assign in_stall = q_status.full;
  assign accept = in_valid && !q_status.full;

  // A sequence is open while fewer bytes than its length are gathered.
  assign seq_open = (expected_length >= LEN_2) && (expected_length <= LEN_4) &&
                    (gathered_count != 2'd0) &&
                    ({1'b0, gathered_count} < expected_length);
  assign is_cont = (text_byte[7:6] == 2'b10);

  // Value and count after gathering this byte as a continuation.
  assign cp_gathered = {partial_value[CpWidth-7:0], text_byte[5:0]};
  assign count_gathered = {1'b0, gathered_count} + 3'd1;

  // Checks on a completed sequence.
  assign overlong = ((expected_length == LEN_2) && (cp_gathered < MIN_CP_LEN2)) ||
                    ((expected_length == LEN_3) && (cp_gathered < MIN_CP_LEN3)) ||
                    ((expected_length == LEN_4) && (cp_gathered < MIN_CP_LEN4));
  assign out_of_range = (cp_gathered > MAX_CP) ||
                        ((cp_gathered >= SURROGATE_LO) && (cp_gathered <= SURROGATE_HI));

  // Classify the byte and build its job and the next sequence state.
  always_comb begin
    job = '0;
    expected_length_next = LEN_NONE;
    gathered_count_next = 2'd0;
    partial_value_next = '0;
    if (seq_open && is_cont) begin
      if (count_gathered >= expected_length) begin
        // Sequence complete: the state closes.
        if (overlong) begin
          job.rep_count = expected_length;
        end else if (out_of_range) begin
          job.tail_valid = 1'b1;
          job.tail_cp = REPLACEMENT_CP;
          job.tail_used = expected_length;
          job.tail_bad = 1'b1;
        end else begin
          job.tail_valid = 1'b1;
          job.tail_cp = cp_gathered;
          job.tail_used = expected_length;
        end
      end else begin
        expected_length_next = expected_length;
        gathered_count_next = count_gathered[1:0];
        partial_value_next = cp_gathered;
      end
    end else begin
      // An interrupted sequence flushes one replacement per gathered byte.
      if (seq_open) begin
        job.rep_count = {1'b0, gathered_count};
      end
      // The byte itself is then taken as a new lead.
      if (text_byte == 8'h00) begin
        job.tail_valid = 1'b1;
        job.tail_cp = END_MARKER_CP;
        job.tail_used = LEN_NONE;
        job.tail_done = 1'b1;
      end else if (text_byte[7] == 1'b0) begin
        job.tail_valid = 1'b1;
        job.tail_cp = {{(CpWidth-8){1'b0}}, text_byte};
        job.tail_used = LEN_1;
      end else if (text_byte[7:5] == 3'b110) begin
        expected_length_next = LEN_2;
        gathered_count_next = 2'd1;
        partial_value_next = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
      end else if (text_byte[7:4] == 4'b1110) begin
        expected_length_next = LEN_3;
        gathered_count_next = 2'd1;
        partial_value_next = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
      end else if (text_byte[7:3] == 5'b11110) begin
        expected_length_next = LEN_4;
        gathered_count_next = 2'd1;
        partial_value_next = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
      end else begin
        job.tail_valid = 1'b1;
        job.tail_cp = REPLACEMENT_CP;
        job.tail_used = LEN_1;
        job.tail_bad = 1'b1;
      end
    end
  end

  // Only jobs that produce results go into the queue.
  assign push = accept && ((job.rep_count != 3'd0) || job.tail_valid);

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= LEN_NONE;
      gathered_count <= 2'd0;
      partial_value <= '0;
    end else if (accept) begin
      expected_length <= expected_length_next;
      gathered_count <= gathered_count_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

### rtl/u8dec_queue.sv
// Short job queue that decouples the decoder front end from the back end.
// Depends on u8dec_pkg.
module u8dec_queue
  import u8dec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head_job,
  output queue_status_t status
);

  job_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign status.full = (count == QueueCntW'(QueueDepth));
  assign status.empty = (count == '0);
  assign head_job = entries[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/u8dec_back.sv
// Back end of the UTF-8 stream decoder: expands each queued job into its
// results and holds them in the output register. Depends on u8dec_pkg.
module u8dec_back
  import u8dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  job_t               head_job,
  input  queue_status_t      q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CpWidth-1:0] code_point,
  output logic [2:0]         bytes_used,
  output logic               bad_sequence,
  output logic               text_done,
  output logic               run_last
);

  logic [2:0]         rep_index;
  logic [2:0]         rep_index_next;
  logic               load;
  logic               in_reps;
  logic               last;
  logic [CpWidth-1:0] cp_sel;
  logic [2:0]         used_sel;
  logic               bad_sel;
  logic               done_sel;

  // The output register takes a new result when it is empty or being taken.
  assign load = !q_status.empty && (!out_valid || !out_stall);
  assign in_reps = (rep_index < head_job.rep_count);

  // Select the result at the current position in the job.
  always_comb begin
    if (in_reps) begin
      cp_sel = REPLACEMENT_CP;
      used_sel = LEN_1;
      bad_sel = 1'b1;
      done_sel = 1'b0;
      last = ((rep_index + 3'd1) == head_job.rep_count) && !head_job.tail_valid;
    end else begin
      cp_sel = head_job.tail_cp;
      used_sel = head_job.tail_used;
      bad_sel = head_job.tail_bad;
      done_sel = head_job.tail_done;
      last = 1'b1;
    end
  end

  assign pop = load && last;
  assign rep_index_next = last ? 3'd0 : rep_index + 3'd1;

  // Position within the current job and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_index <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rep_index <= rep_index_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= cp_sel;
      bytes_used <= used_sel;
      bad_sequence <= bad_sel;
      text_done <= done_sel;
      run_last <= last;
    end
  end

endmodule
